[src/jpeg_frame_size_scanner_core_macros.svh]
// Assertion macros for the JPEG frame size scanner.
// No dependencies; included by the core after its package import.
`ifndef JPEG_FRAME_SIZE_SCANNER_CORE_MACROS_SVH
`define JPEG_FRAME_SIZE_SCANNER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define JFSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define JFSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/jfss_pkg.sv]
// Package for the JPEG frame size scanner: scan phase codes, status codes,
// marker byte constants and the start-of-frame test. No dependencies.
`default_nettype none

package jfss_pkg;

   localparam int PHASE_W = 4;

   localparam logic [PHASE_W-1:0] PH_START_FF = 4'd0;
   localparam logic [PHASE_W-1:0] PH_START_D8 = 4'd1;
   localparam logic [PHASE_W-1:0] PH_HUNT     = 4'd2;
   localparam logic [PHASE_W-1:0] PH_FILL     = 4'd3;
   localparam logic [PHASE_W-1:0] PH_SOF_LHI  = 4'd4;
   localparam logic [PHASE_W-1:0] PH_SOF_LLO  = 4'd5;
   localparam logic [PHASE_W-1:0] PH_SOF_PREC = 4'd6;
   localparam logic [PHASE_W-1:0] PH_SOF_HHI  = 4'd7;
   localparam logic [PHASE_W-1:0] PH_SOF_HLO  = 4'd8;
   localparam logic [PHASE_W-1:0] PH_SOF_WHI  = 4'd9;
   localparam logic [PHASE_W-1:0] PH_SOF_WLO  = 4'd10;
   localparam logic [PHASE_W-1:0] PH_SEG_LHI  = 4'd11;
   localparam logic [PHASE_W-1:0] PH_SEG_LLO  = 4'd12;
   localparam logic [PHASE_W-1:0] PH_SKIP     = 4'd13;
   localparam logic [PHASE_W-1:0] PH_DONE     = 4'd14;

   typedef logic [1:0] status_type;

   localparam status_type ST_SCANNING  = 2'd0;
   localparam status_type ST_FOUND     = 2'd1;
   localparam status_type ST_MALFORMED = 2'd2;
   localparam status_type ST_NOFRAME   = 2'd3;

   localparam logic [7:0] MK_FILL  = 8'hFF;
   localparam logic [7:0] MK_SOI   = 8'hD8;
   localparam logic [7:0] MK_SOS   = 8'hDA;
   localparam logic [7:0] MK_EOI   = 8'hD9;
   localparam logic [7:0] MK_SOF_LO = 8'hC0;
   localparam logic [7:0] MK_SOF_HI = 8'hCF;
   localparam logic [7:0] MK_DHT   = 8'hC4;
   localparam logic [7:0] MK_JPG   = 8'hC8;
   localparam logic [7:0] MK_DAC   = 8'hCC;

   localparam logic [15:0] MIN_SEG_LEN = 16'd2;

   function automatic logic is_sof(input logic [7:0] code);
      is_sof = (code >= MK_SOF_LO) && (code <= MK_SOF_HI) &&
               (code != MK_DHT) && (code != MK_JPG) && (code != MK_DAC);
   endfunction

endpackage

`default_nettype wire

[src/jpeg_frame_size_scanner_core.sv]
// JPEG frame size scanner: the single module of the block.
// Depends on jfss_pkg and jpeg_frame_size_scanner_core_macros.svh.
//
// Usage: the request channel carries one byte of a JPEG file per word, with
// req_first_byte set on the first byte of each file, which restarts the scan.
// Every request word produces exactly one response word on the rsp_ channel:
// rsp_status is 0 while scanning, 1 when the frame size was found (width and
// height then valid), 2 on a malformed stream and 3 when a scan or end marker
// arrives before any frame header. Sizes read zero unless status is 1.
// After a final status, later bytes answer with status 0 until the next
// first byte.
// The response is valid in the cycle after request acceptance, and the block
// takes one byte every cycle while req_stall is low; the byte decode sits
// between the scan state registers and a single response register.
// When the receiver stalls, the response register holds its word and
// req_stall is raised only while that register is full and stalled.
// Synchronous reset empties the response register and sets the scan to
// expect the opening 0xFF of a file.
`default_nettype none

module jpeg_frame_size_scanner_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic [7:0]             req_data_byte,
   input  wire logic                   req_first_byte,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      jfss_pkg::status_type   rsp_status,
   output      logic [15:0]            rsp_frame_width,
   output      logic [15:0]            rsp_frame_height
);

   import jfss_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in, phase_cur;
   logic [15:0]        bytes_left_ff, bytes_left_in, bytes_left_cur, bytes_dec;
   logic               garbage_ff, garbage_in, garbage_cur;
   logic [7:0]         hold_ff, hold_in, hold_cur;
   logic [15:0]        width_ff, width_in, width_cur;
   logic [15:0]        height_ff, height_in, height_cur;
   logic [15:0]        seg_len;
   status_type         status_in;

   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [15:0]        rsp_width_ff, rsp_height_ff;

   logic               accept;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (req_first_byte) begin
         phase_cur      = PH_START_FF;
         bytes_left_cur = '0;
         garbage_cur    = 1'b0;
         hold_cur       = '0;
         width_cur      = '0;
         height_cur     = '0;
      end else begin
         phase_cur      = phase_ff;
         bytes_left_cur = bytes_left_ff;
         garbage_cur    = garbage_ff;
         hold_cur       = hold_ff;
         width_cur      = width_ff;
         height_cur     = height_ff;
      end
   end

   assign seg_len   = {hold_cur, req_data_byte};
   assign bytes_dec = bytes_left_cur - 16'd1;

   always_comb begin
      phase_in      = phase_cur;
      bytes_left_in = bytes_left_cur;
      garbage_in    = garbage_cur;
      hold_in       = hold_cur;
      width_in      = width_cur;
      height_in     = height_cur;
      status_in     = ST_SCANNING;
      unique case (phase_cur)
         PH_START_FF: begin
            if (req_data_byte == MK_FILL) begin
               phase_in = PH_START_D8;
            end else begin
               status_in = ST_MALFORMED;
               phase_in  = PH_DONE;
            end
         end
         PH_START_D8: begin
            if (req_data_byte == MK_SOI) begin
               phase_in   = PH_HUNT;
               garbage_in = 1'b0;
            end else begin
               status_in = ST_MALFORMED;
               phase_in  = PH_DONE;
            end
         end
         PH_HUNT: begin
            if (req_data_byte == MK_FILL) begin
               phase_in = PH_FILL;
            end else begin
               garbage_in = 1'b1;
            end
         end
         PH_FILL: begin
            if (req_data_byte == MK_FILL) begin
               phase_in = PH_FILL;
            end else if (garbage_cur) begin
               status_in = ST_MALFORMED;
               phase_in  = PH_DONE;
            end else if (is_sof(req_data_byte)) begin
               phase_in = PH_SOF_LHI;
            end else if (req_data_byte == MK_SOS || req_data_byte == MK_EOI) begin
               status_in = ST_NOFRAME;
               phase_in  = PH_DONE;
            end else begin
               phase_in = PH_SEG_LHI;
            end
         end
         PH_SOF_LHI:  phase_in = PH_SOF_LLO;
         PH_SOF_LLO:  phase_in = PH_SOF_PREC;
         PH_SOF_PREC: phase_in = PH_SOF_HHI;
         PH_SOF_HHI: begin
            hold_in  = req_data_byte;
            phase_in = PH_SOF_HLO;
         end
         PH_SOF_HLO: begin
            height_in = seg_len;
            phase_in  = PH_SOF_WHI;
         end
         PH_SOF_WHI: begin
            hold_in  = req_data_byte;
            phase_in = PH_SOF_WLO;
         end
         PH_SOF_WLO: begin
            width_in  = seg_len;
            status_in = ST_FOUND;
            phase_in  = PH_DONE;
         end
         PH_SEG_LHI: begin
            hold_in  = req_data_byte;
            phase_in = PH_SEG_LLO;
         end
         PH_SEG_LLO: begin
            if (seg_len < MIN_SEG_LEN) begin
               status_in = ST_MALFORMED;
               phase_in  = PH_DONE;
            end else if (seg_len == MIN_SEG_LEN) begin
               garbage_in = 1'b0;
               phase_in   = PH_HUNT;
            end else begin
               bytes_left_in = seg_len - MIN_SEG_LEN;
               phase_in      = PH_SKIP;
            end
         end
         PH_SKIP: begin
            bytes_left_in = bytes_dec;
            if (bytes_dec == 16'd0) begin
               garbage_in = 1'b0;
               phase_in   = PH_HUNT;
            end
         end
         default: phase_in = PH_DONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START_FF;
         bytes_left_ff <= '0;
         garbage_ff    <= 1'b0;
         hold_ff       <= '0;
         width_ff      <= '0;
         height_ff     <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         garbage_ff    <= garbage_in;
         hold_ff       <= hold_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= status_in;
         rsp_width_ff  <= (status_in == ST_FOUND) ? width_in : 16'd0;
         rsp_height_ff <= (status_in == ST_FOUND) ? height_in : 16'd0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_frame_width  = rsp_width_ff;
   assign rsp_frame_height = rsp_height_ff;

`include "jpeg_frame_size_scanner_core_macros.svh"

   `JFSS_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, accept, rsp_valid, "accepted word gave no response")
   `JFSS_ASSERT_NOW(a_stall_only_when_full, clock, reset, req_stall, rsp_valid_ff, "request stalled with empty response register")
   `JFSS_ASSERT_NOW(a_sizes_zero_unless_found, clock, reset, rsp_valid && rsp_status != ST_FOUND, rsp_frame_width == 16'd0 && rsp_frame_height == 16'd0, "sizes nonzero without found status")
   `JFSS_ASSERT_NEXT(a_done_stays_quiet, clock, reset, accept && phase_ff == PH_DONE && !req_first_byte, rsp_status == ST_SCANNING && phase_ff == PH_DONE, "scan left done state without restart")

endmodule

`default_nettype wire

[verif/tb_jpeg_frame_size_scanner_core.sv]
// Self-checking testbench for jpeg_frame_size_scanner_core: feeds JPEG byte streams,
// predicts every response word and compares it field by field with the block's output.
// Depends on jfss_pkg and the core module.
`timescale 1ns / 100ps

module tb_jpeg_frame_size_scanner_core;
   import jfss_pkg::*;

   localparam int ITEM_TARGET = 1900;
   localparam int PAUSE_EVERY = 400;
   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [7:0] MK_APP1 = 8'hE1;

   typedef struct {
      logic [7:0] data;
      logic       first;
      bit         drain;
   } file_byte_type;

   typedef struct {
      status_type  status;
      logic [15:0] frame_width;
      logic [15:0] frame_height;
   } size_word_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [7:0]        req_data_byte = 8'h00;
   logic              req_first_byte = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   status_type        rsp_status;
   logic [15:0]       rsp_frame_width;
   logic [15:0]       rsp_frame_height;

   file_byte_type     pending_bytes[$];
   size_word_type     expected_sizes[$];
   bit                hold_next = 1'b0;
   int                counted_bytes = 0;
   int                files_built = 0;
   int                bytes_sent = 0;
   int                words_checked = 0;
   int                error_count = 0;
   int                found_count = 0;
   int                malformed_count = 0;
   int                noframe_count = 0;
   int                burst_left = 10;
   int                gap_left = 0;
   int                idle_cycles = 0;
   int                stall_tick = 0;
   int                stall_mode = 0;
   logic [7:0]        stall_mask = 8'h00;

   // Scan state of the predictor.
   logic [3:0]        scan_phase = PH_START_FF;
   logic [15:0]       skip_count = '0;
   logic              garbage_flag = 1'b0;
   logic [7:0]        hold_byte = '0;
   logic [15:0]       width_q = '0;
   logic [15:0]       height_q = '0;

   jpeg_frame_size_scanner_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_first_byte   (req_first_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_frame_width  (rsp_frame_width),
      .rsp_frame_height (rsp_frame_height)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic bit frame_code(input logic [7:0] code);
      return code >= MK_SOF_LO && code <= MK_SOF_HI &&
             !(code inside {MK_DHT, MK_JPG, MK_DAC});
   endfunction

   function automatic size_word_type scan_predict(input logic [7:0] b, input logic first);
      size_word_type w;
      logic [15:0]   seg_len;
      w.status = ST_SCANNING;
      w.frame_width = '0;
      w.frame_height = '0;
      if (first) begin
         scan_phase = PH_START_FF;
         skip_count = '0;
         garbage_flag = 1'b0;
         hold_byte = '0;
         width_q = '0;
         height_q = '0;
      end
      case (scan_phase)
         PH_START_FF: begin
            if (b == MK_FILL) scan_phase = PH_START_D8;
            else begin
               w.status = ST_MALFORMED;
               scan_phase = PH_DONE;
            end
         end
         PH_START_D8: begin
            if (b == MK_SOI) begin
               scan_phase = PH_HUNT;
               garbage_flag = 1'b0;
            end else begin
               w.status = ST_MALFORMED;
               scan_phase = PH_DONE;
            end
         end
         PH_HUNT: begin
            if (b == MK_FILL) scan_phase = PH_FILL;
            else garbage_flag = 1'b1;
         end
         PH_FILL: begin
            if (b != MK_FILL) begin
               if (garbage_flag) begin
                  w.status = ST_MALFORMED;
                  scan_phase = PH_DONE;
               end else if (frame_code(b)) begin
                  scan_phase = PH_SOF_LHI;
               end else if (b == MK_SOS || b == MK_EOI) begin
                  w.status = ST_NOFRAME;
                  scan_phase = PH_DONE;
               end else begin
                  scan_phase = PH_SEG_LHI;
               end
            end
         end
         PH_SOF_LHI: scan_phase = PH_SOF_LLO;
         PH_SOF_LLO: scan_phase = PH_SOF_PREC;
         PH_SOF_PREC: scan_phase = PH_SOF_HHI;
         PH_SOF_HHI: begin
            hold_byte = b;
            scan_phase = PH_SOF_HLO;
         end
         PH_SOF_HLO: begin
            height_q = {hold_byte, b};
            scan_phase = PH_SOF_WHI;
         end
         PH_SOF_WHI: begin
            hold_byte = b;
            scan_phase = PH_SOF_WLO;
         end
         PH_SOF_WLO: begin
            width_q = {hold_byte, b};
            w.status = ST_FOUND;
            scan_phase = PH_DONE;
         end
         PH_SEG_LHI: begin
            hold_byte = b;
            scan_phase = PH_SEG_LLO;
         end
         PH_SEG_LLO: begin
            seg_len = {hold_byte, b};
            if (seg_len < MIN_SEG_LEN) begin
               w.status = ST_MALFORMED;
               scan_phase = PH_DONE;
            end else if (seg_len == MIN_SEG_LEN) begin
               garbage_flag = 1'b0;
               scan_phase = PH_HUNT;
            end else begin
               skip_count = seg_len - MIN_SEG_LEN;
               scan_phase = PH_SKIP;
            end
         end
         PH_SKIP: begin
            skip_count = skip_count - 16'd1;
            if (skip_count == '0) begin
               garbage_flag = 1'b0;
               scan_phase = PH_HUNT;
            end
         end
         default: scan_phase = PH_DONE;
      endcase
      if (w.status == ST_FOUND) begin
         w.frame_width = width_q;
         w.frame_height = height_q;
      end
      return w;
   endfunction

   task automatic queue_byte(input logic [7:0] b, input logic first, input bit counted);
      file_byte_type item;
      item.data = b;
      item.first = first;
      item.drain = hold_next;
      hold_next = 1'b0;
      pending_bytes.push_back(item);
      if (counted) counted_bytes++;
   endtask

   function automatic logic [7:0] pick_payload();
      return ($urandom_range(0, 7) == 0) ? MK_FILL : 8'($urandom);
   endfunction

   function automatic logic [15:0] pick_dim();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_plain_code();
      logic [7:0] c;
      do begin
         case ($urandom_range(0, 5))
            0: c = MK_DHT;
            1: c = MK_JPG;
            2: c = MK_DAC;
            default: c = 8'($urandom);
         endcase
      end while (frame_code(c) || c == MK_FILL || c == MK_SOS || c == MK_EOI);
      return c;
   endfunction

   task automatic queue_tail();
      repeat ($urandom_range(0, 3)) queue_byte(8'($urandom), 1'b0, 1'b0);
   endtask

   task automatic queue_garbage();
      repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 254)), 1'b0, 1'b1);
   endtask

   task automatic queue_marker(input logic [7:0] code);
      queue_byte(MK_FILL, 1'b0, 1'b1);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) queue_byte(MK_FILL, 1'b0, 1'b1);
      queue_byte(code, 1'b0, 1'b1);
   endtask

   // Mostly well-formed files; the rest open badly, carry garbage or short
   // lengths, or are cut short and restarted by the next file.
   task automatic queue_file();
      int          kind;
      int          nseg;
      int          flaw_seg;
      int          s;
      logic [7:0]  code;
      logic [15:0] seg_len;
      logic [15:0] dim;
      kind = $urandom_range(0, 99);
      files_built++;
      if (kind < 5) begin
         queue_byte(8'($urandom_range(0, 254)), 1'b1, 1'b1);
         queue_tail();
         return;
      end
      queue_byte(MK_FILL, 1'b1, 1'b1);
      if (kind < 10) begin
         do code = 8'($urandom); while (code == MK_SOI);
         queue_byte(code, 1'b0, 1'b1);
         queue_tail();
         return;
      end
      queue_byte(MK_SOI, 1'b0, 1'b1);
      nseg = $urandom_range(0, 3);
      flaw_seg = $urandom_range(0, nseg);
      for (s = 0; s < nseg; s++) begin
         if (kind < 20 && s == flaw_seg) queue_garbage();
         queue_marker(pick_plain_code());
         if (kind >= 20 && kind < 28 && s == flaw_seg) begin
            queue_byte(8'h00, 1'b0, 1'b1);
            queue_byte(8'($urandom_range(0, 1)), 1'b0, 1'b1);
            queue_tail();
            return;
         end
         if ($urandom_range(0, 9) == 0) seg_len = MIN_SEG_LEN;
         else if ($urandom_range(0, 19) == 0) seg_len = 16'($urandom_range(30, 80));
         else seg_len = 16'($urandom_range(3, 14));
         queue_byte(seg_len[15:8], 1'b0, 1'b1);
         queue_byte(seg_len[7:0], 1'b0, 1'b1);
         repeat (seg_len - MIN_SEG_LEN) queue_byte(pick_payload(), 1'b0, 1'b1);
      end
      if (kind >= 28 && kind < 36) return;
      if (kind < 20 && flaw_seg == nseg) queue_garbage();
      if ($urandom_range(0, 4) == 0) begin
         queue_marker(($urandom_range(0, 1) == 0) ? MK_SOS : MK_EOI);
         queue_tail();
         return;
      end
      do code = 8'($urandom_range(MK_SOF_LO, MK_SOF_HI)); while (!frame_code(code));
      queue_marker(code);
      repeat (3) queue_byte(8'($urandom), 1'b0, 1'b1);
      dim = pick_dim();
      queue_byte(dim[15:8], 1'b0, 1'b1);
      queue_byte(dim[7:0], 1'b0, 1'b1);
      dim = pick_dim();
      queue_byte(dim[15:8], 1'b0, 1'b1);
      queue_byte(dim[7:0], 1'b0, 1'b1);
      queue_tail();
   endtask

   always @(posedge clock) begin : driver
      file_byte_type item;
      bit            accepted;
      accepted = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (accepted) begin
            expected_sizes.push_back(scan_predict(req_data_byte, req_first_byte));
            bytes_sent <= bytes_sent + 1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(1, 20);
               gap_left = $urandom_range(0, 6);
            end
         end
         if (!req_valid || accepted) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() > 0 &&
                         (!pending_bytes[0].drain ||
                          (!accepted && words_checked == bytes_sent))) begin
               item = pending_bytes.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= item.data;
               req_first_byte <= item.first;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : receiver_stall
      stall_tick++;
      if (stall_tick % 64 == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_mask = 8'($urandom);
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 2) == 0);
         2: rsp_stall <= stall_mask[stall_tick % 8];
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin : monitor
      size_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_checked <= words_checked + 1;
         if (expected_sizes.size() == 0) begin
            $display("%0t: unexpected word, status %0d width %0d height %0d",
                     $time, rsp_status, rsp_frame_width, rsp_frame_height);
            error_count++;
         end else begin
            want = expected_sizes.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_status);
               error_count++;
            end
            if (rsp_frame_width !== want.frame_width) begin
               $display("%0t: frame_width expected %0d, got %0d",
                        $time, want.frame_width, rsp_frame_width);
               error_count++;
            end
            if (rsp_frame_height !== want.frame_height) begin
               $display("%0t: frame_height expected %0d, got %0d",
                        $time, want.frame_height, rsp_frame_height);
               error_count++;
            end
            case (want.status)
               ST_FOUND: found_count++;
               ST_MALFORMED: malformed_count++;
               ST_NOFRAME: noframe_count++;
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
         $display("jpeg_frame_size_scanner_core regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      // Directed files; the first one arrives before any first-byte flag.
      queue_byte(MK_FILL, 1'b0, 1'b1);
      queue_byte(MK_SOI, 1'b0, 1'b1);
      queue_byte(MK_FILL, 1'b0, 1'b1);
      queue_byte(MK_SOF_LO, 1'b0, 1'b1);
      queue_byte(8'h00, 1'b0, 1'b1);
      queue_byte(8'h11, 1'b0, 1'b1);
      queue_byte(8'h08, 1'b0, 1'b1);
      queue_byte(8'hFF, 1'b0, 1'b1);
      queue_byte(8'hFF, 1'b0, 1'b1);
      queue_byte(8'h00, 1'b0, 1'b1);
      queue_byte(8'h00, 1'b0, 1'b1);
      queue_byte(8'h00, 1'b1, 1'b1);
      queue_byte(MK_FILL, 1'b1, 1'b1);
      queue_byte(8'h00, 1'b0, 1'b1);
      queue_byte(MK_FILL, 1'b1, 1'b1);
      queue_byte(MK_SOI, 1'b0, 1'b1);
      queue_byte(8'h12, 1'b0, 1'b1);
      queue_byte(MK_FILL, 1'b0, 1'b1);
      queue_byte(MK_FILL, 1'b0, 1'b1);
      queue_byte(MK_EOI, 1'b0, 1'b1);
      queue_byte(MK_FILL, 1'b1, 1'b1);
      queue_byte(MK_SOI, 1'b0, 1'b1);
      queue_byte(MK_FILL, 1'b0, 1'b1);
      queue_byte(MK_DHT, 1'b0, 1'b1);
      queue_byte(8'h00, 1'b0, 1'b1);
      queue_byte(8'h02, 1'b0, 1'b1);
      queue_byte(MK_FILL, 1'b0, 1'b1);
      queue_byte(MK_APP1, 1'b0, 1'b1);
      queue_byte(8'h00, 1'b0, 1'b1);
      queue_byte(8'h01, 1'b0, 1'b1);
      hold_next = 1'b1;
      while (counted_bytes < ITEM_TARGET) begin
         if (counted_bytes >= PAUSE_EVERY * (counted_bytes / PAUSE_EVERY) &&
             $urandom_range(0, 39) == 0)
            hold_next = 1'b1;
         queue_file();
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_bytes.size() > 0 || req_valid || words_checked != bytes_sent);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (expected_sizes.size() > 0) begin
         $display("%0t: %0d expected words never arrived", $time, expected_sizes.size());
         error_count += expected_sizes.size();
      end
      $display("Checked %0d words from %0d files: %0d sizes found, %0d malformed, %0d ended",
               words_checked, files_built, found_count, malformed_count, noframe_count);
      $display("at a scan or end marker; %0d mismatches.", error_count);
      if (error_count == 0) begin
         $display("jpeg_frame_size_scanner_core regression: pass");
      end else begin
         $display("jpeg_frame_size_scanner_core regression: fail");
      end
      $finish;
   end

endmodule
